### design/nms_pkg.sv
// Shared constants and types for the 3x3 neighbour mean smoother.
package nms_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF    = 4096;
  localparam int unsigned PIXEL_BITS_DEF  = 8;

  localparam int unsigned ROWS_CFG_W = 13;
  localparam int unsigned COLS_CFG_W = 11;
  localparam int unsigned CFG_W      = 13;

  localparam logic CFG_IDX_ROWS = 1'b0;
  localparam logic CFG_IDX_COLS = 1'b1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    DIV3,
    DIV5,
    DIV8
  } div_e;

  typedef struct packed {
    logic pixel;
    logic emit1;
    logic emit2;
    logic top;
    logic left;
    logic right;
    logic last;
  } op_t;

  typedef struct packed {
    logic two;
    logic frame_done;
  } res_flags_t;

endpackage

### design/neighbour_mean_smoother_3x3_unit.sv
// Top level of the streaming 3x3 neighbour mean smoother.
// A result passes the s1 and s2 registers and the result queue before it is offered.
// One transaction per cycle while in_ready_o is high; a row end yields two results.
// The accept rate is set by the four-entry result queue and the s1 and s2 results.
// Reset is asynchronous and active low: positions, drain mode, window and queue clear,
// the frame size returns to 2x2, and the line buffers are not cleared.
module neighbour_mean_smoother_3x3_unit import nms_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned PIXEL_BITS  = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] smoothed_o,
  output logic                  frame_done_o,
  output logic                  run_end_o
);

  logic                  s1_valid;
  op_t                   s1_op;
  logic [PIXEL_BITS-1:0] s1_pixel;
  logic [PIXEL_BITS-1:0] up_a, up_b, up_c, mid_a, mid_b;
  logic                  s2_busy;
  logic                  res_valid;
  logic [PIXEL_BITS-1:0] res_first, res_second;
  res_flags_t            res_flags;
  logic [FIFO_CNT_W-1:0] fifo_count;

  nms_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .pixel_in_i   (pixel_in_i),
    .fifo_count_i (fifo_count),
    .s2_busy_i    (s2_busy),
    .s1_valid_o   (s1_valid),
    .s1_op_o      (s1_op),
    .s1_pixel_o   (s1_pixel),
    .up_a_o       (up_a),
    .up_b_o       (up_b),
    .up_c_o       (up_c),
    .mid_a_o      (mid_a),
    .mid_b_o      (mid_b)
  );

  nms_mean #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid),
    .s1_op_i      (s1_op),
    .s1_pixel_i   (s1_pixel),
    .up_a_i       (up_a),
    .up_b_i       (up_b),
    .up_c_i       (up_c),
    .mid_a_i      (mid_a),
    .mid_b_i      (mid_b),
    .s2_busy_o    (s2_busy),
    .res_valid_o  (res_valid),
    .res_first_o  (res_first),
    .res_second_o (res_second),
    .res_flags_o  (res_flags)
  );

  nms_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_first_i  (res_first),
    .res_second_i (res_second),
    .res_flags_i  (res_flags),
    .fifo_count_o (fifo_count),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .smoothed_o   (smoothed_o),
    .frame_done_o (frame_done_o),
    .run_end_o    (run_end_o)
  );

endmodule

### design/nms_ram.sv
// Generic two-read, one-write RAM with registered, write-through reads.
module nms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/nms_front.sv
// Front end: configuration, transaction acceptance, frame positions and line buffers.
module nms_front import nms_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned PIXEL_BITS  = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  input  logic [FIFO_CNT_W-1:0] fifo_count_i,
  input  logic                  s2_busy_i,
  output logic                  s1_valid_o,
  output op_t                   s1_op_o,
  output logic [PIXEL_BITS-1:0] s1_pixel_o,
  output logic [PIXEL_BITS-1:0] up_a_o,
  output logic [PIXEL_BITS-1:0] up_b_o,
  output logic [PIXEL_BITS-1:0] up_c_o,
  output logic [PIXEL_BITS-1:0] mid_a_o,
  output logic [PIXEL_BITS-1:0] mid_b_o
);

  localparam int unsigned COL_W = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS);
  localparam int unsigned CCW = (COLS_CFG_W > COL_W + 1) ? COLS_CFG_W : COL_W + 1;
  localparam int unsigned RCW = (ROWS_CFG_W > ROW_W + 1) ? ROWS_CFG_W : ROW_W + 1;
  localparam int unsigned SLW = FIFO_CNT_W + 1;

  logic [COL_W-1:0]      last_col_q, last_col_d;
  logic [ROW_W-1:0]      last_row_q, last_row_d;
  logic [COL_W-1:0]      col_pos_q, col_pos_d;
  logic [ROW_W-1:0]      row_pos_q, row_pos_d;
  logic [COL_W-1:0]      drain_pos_q, drain_pos_d;
  logic                  draining_q, draining_d;
  logic                  s1_valid_q;
  op_t                   s1_op_q, op_d;
  logic [PIXEL_BITS-1:0] s1_pixel_q;
  logic [COL_W-1:0]      s1_addr_q;

  logic [CCW-1:0]   cols_lim;
  logic [RCW-1:0]   rows_lim;
  logic             accept, go, s1_emit, s1_write;
  logic [COL_W-1:0] c_eff, d_eff, addr_a, addr_b;
  logic [ROW_W-1:0] r_eff;
  logic             c_last, r_last, d_last;
  logic             c_ge1, c_ge2, r_ge1, r_ge2;

  always_comb begin
    cols_lim = CCW'(cfg_wdata_i[COLS_CFG_W-1:0]);
    if (cols_lim < CCW'(2)) begin
      cols_lim = CCW'(2);
    end else if (cols_lim > CCW'(MAX_COLUMNS)) begin
      cols_lim = CCW'(MAX_COLUMNS);
    end
    rows_lim = RCW'(cfg_wdata_i[ROWS_CFG_W-1:0]);
    if (rows_lim < RCW'(2)) begin
      rows_lim = RCW'(2);
    end else if (rows_lim > RCW'(MAX_ROWS)) begin
      rows_lim = RCW'(MAX_ROWS);
    end
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_ROWS: last_row_d = ROW_W'(rows_lim - RCW'(1));
        CFG_IDX_COLS: last_col_d = COL_W'(cols_lim - CCW'(1));
        default: ;
      endcase
    end
  end

  assign s1_emit  = s1_valid_q & (~s1_op_q.pixel | s1_op_q.emit1);
  assign in_ready_o = ({1'b0, fifo_count_i} + SLW'(s1_emit) + SLW'(s2_busy_i))
                      < SLW'(FIFO_DEPTH);
  assign accept = in_valid_i & in_ready_o;
  assign go     = accept & (action_i == draining_q);

  assign c_eff  = (col_pos_q > last_col_q) ? last_col_q : col_pos_q;
  assign d_eff  = (drain_pos_q > last_col_q) ? last_col_q : drain_pos_q;
  assign r_eff  = (row_pos_q > last_row_q) ? last_row_q : row_pos_q;
  assign c_last = (c_eff == last_col_q);
  assign d_last = (d_eff == last_col_q);
  assign r_last = (r_eff == last_row_q);
  assign c_ge1  = (c_eff != '0);
  assign r_ge1  = (r_eff != '0);
  assign c_ge2  = ({1'b0, c_eff} >= (COL_W + 1)'(2));
  assign r_ge2  = ({1'b0, r_eff} >= (ROW_W + 1)'(2));

  assign addr_a = action_i ? (d_eff - COL_W'(1)) : c_eff;
  assign addr_b = d_eff + COL_W'(1);

  always_comb begin
    op_d.pixel = ~action_i;
    op_d.emit1 = r_ge1 & c_ge1;
    op_d.emit2 = r_ge1 & c_ge1 & c_last;
    op_d.top   = r_ge2;
    op_d.left  = action_i ? (d_eff != '0) : c_ge2;
    op_d.right = ~d_last;
    op_d.last  = d_last;

    col_pos_d   = col_pos_q;
    row_pos_d   = row_pos_q;
    drain_pos_d = drain_pos_q;
    draining_d  = draining_q;
    if (go && !action_i) begin
      if (c_last) begin
        col_pos_d = '0;
        if (r_last) begin
          row_pos_d   = '0;
          draining_d  = 1'b1;
          drain_pos_d = '0;
        end else begin
          row_pos_d = r_eff + ROW_W'(1);
        end
      end else begin
        col_pos_d = c_eff + COL_W'(1);
        row_pos_d = r_eff;
      end
    end else if (go) begin
      if (d_last) begin
        draining_d  = 1'b0;
        drain_pos_d = '0;
      end else begin
        drain_pos_d = d_eff + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q  <= COL_W'(1);
      last_row_q  <= ROW_W'(1);
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      drain_pos_q <= '0;
      draining_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      last_col_q  <= last_col_d;
      last_row_q  <= last_row_d;
      col_pos_q   <= col_pos_d;
      row_pos_q   <= row_pos_d;
      drain_pos_q <= drain_pos_d;
      draining_q  <= draining_d;
      s1_valid_q  <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_op_q    <= op_d;
      s1_pixel_q <= pixel_in_i;
      s1_addr_q  <= c_eff;
    end
  end

  assign s1_write = s1_valid_q & s1_op_q.pixel;

  nms_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLUMNS)) u_ram_up (
    .clk_i     (clk_i),
    .we_i      (s1_write),
    .waddr_i   (s1_addr_q),
    .wdata_i   (mid_a_o),
    .re_i      (go),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (up_a_o),
    .rdata_b_o (up_b_o)
  );

  nms_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLUMNS)) u_ram_up_copy (
    .clk_i     (clk_i),
    .we_i      (s1_write),
    .waddr_i   (s1_addr_q),
    .wdata_i   (mid_a_o),
    .re_i      (go),
    .raddr_a_i (d_eff),
    .raddr_b_i (d_eff),
    .rdata_a_o (up_c_o),
    .rdata_b_o ()
  );

  nms_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLUMNS)) u_ram_mid (
    .clk_i     (clk_i),
    .we_i      (s1_write),
    .waddr_i   (s1_addr_q),
    .wdata_i   (s1_pixel_q),
    .re_i      (go),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (mid_a_o),
    .rdata_b_o (mid_b_o)
  );

  assign s1_valid_o = s1_valid_q;
  assign s1_op_o    = s1_op_q;
  assign s1_pixel_o = s1_pixel_q;

  // The final drain transaction of a frame always leaves drain mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i && draining_q && d_last) |=> !draining_q)
    else $error("drain mode not left after the last drain transaction");

endmodule

### design/nms_mean.sv
// Window update, neighbour sums and constant-divisor rounding stage.
module nms_mean import nms_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s1_valid_i,
  input  op_t                   s1_op_i,
  input  logic [PIXEL_BITS-1:0] s1_pixel_i,
  input  logic [PIXEL_BITS-1:0] up_a_i,
  input  logic [PIXEL_BITS-1:0] up_b_i,
  input  logic [PIXEL_BITS-1:0] up_c_i,
  input  logic [PIXEL_BITS-1:0] mid_a_i,
  input  logic [PIXEL_BITS-1:0] mid_b_i,
  output logic                  s2_busy_o,
  output logic                  res_valid_o,
  output logic [PIXEL_BITS-1:0] res_first_o,
  output logic [PIXEL_BITS-1:0] res_second_o,
  output res_flags_t            res_flags_o
);

  localparam int unsigned SW = PIXEL_BITS + 3;
  localparam int unsigned EW = SW + 3;
  localparam int unsigned PW = SW + EW;
  localparam int unsigned RECIP3 = ((32'd1 << EW) + 32'd2) / 3;
  localparam int unsigned RECIP5 = ((32'd1 << EW) + 32'd4) / 5;

  logic [PIXEL_BITS-1:0] win_q [9];
  logic [PIXEL_BITS-1:0] win_d [9];

  logic             s2_valid_q;
  logic [SW-1:0]    s2_sum1_q, s2_sum2_q, sum1, sum2;
  div_e             s2_k1_q, s2_k2_q, k1, k2;
  res_flags_t       s2_flags_q;
  logic             emit;

  function automatic logic [PIXEL_BITS-1:0] div_mean(input logic [SW-1:0] s,
                                                     input div_e k);
    logic [SW-1:0] m;
    logic [PW-1:0] prod;
    logic [SW-1:0] q;
    begin
      m    = s;
      prod = '0;
      q    = '0;
      case (k)
        DIV3: begin
          m    = s + SW'(1);
          prod = PW'(m) * PW'(RECIP3);
          q    = SW'(prod >> EW);
        end
        DIV5: begin
          m    = s + SW'(2);
          prod = PW'(m) * PW'(RECIP5);
          q    = SW'(prod >> EW);
        end
        DIV8: begin
          m = s + SW'(4);
          q = m >> 3;
        end
        default: q = '0;
      endcase
      return PIXEL_BITS'(q);
    end
  endfunction

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_d[i] = win_q[i];
    end
    if (s1_valid_i && s1_op_i.pixel) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = up_a_i;
      win_d[3] = win_q[4];
      win_d[4] = win_q[5];
      win_d[5] = mid_a_i;
      win_d[6] = win_q[7];
      win_d[7] = win_q[8];
      win_d[8] = s1_pixel_i;
    end
  end

  always_comb begin
    sum1 = '0;
    sum2 = '0;
    k1   = DIV3;
    k2   = DIV3;
    if (s1_op_i.pixel) begin
      sum1 = SW'(win_d[5]) + SW'(win_d[7]) + SW'(win_d[8]);
      if (s1_op_i.top) begin
        sum1 = sum1 + SW'(win_d[1]) + SW'(win_d[2]);
      end
      if (s1_op_i.left) begin
        sum1 = sum1 + SW'(win_d[3]) + SW'(win_d[6]);
      end
      if (s1_op_i.top && s1_op_i.left) begin
        sum1 = sum1 + SW'(win_d[0]);
      end
      if (s1_op_i.top && s1_op_i.left) begin
        k1 = DIV8;
      end else if (s1_op_i.top || s1_op_i.left) begin
        k1 = DIV5;
      end
      sum2 = SW'(win_d[4]) + SW'(win_d[7]) + SW'(win_d[8]);
      if (s1_op_i.top) begin
        sum2 = sum2 + SW'(win_d[1]) + SW'(win_d[2]);
        k2   = DIV5;
      end
    end else begin
      sum1 = SW'(up_c_i);
      if (s1_op_i.left) begin
        sum1 = sum1 + SW'(up_a_i) + SW'(mid_a_i);
      end
      if (s1_op_i.right) begin
        sum1 = sum1 + SW'(up_b_i) + SW'(mid_b_i);
      end
      if (s1_op_i.left && s1_op_i.right) begin
        k1 = DIV5;
      end
    end
  end

  assign emit = s1_valid_i & (~s1_op_i.pixel | s1_op_i.emit1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      s2_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
      s2_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s2_sum1_q             <= sum1;
      s2_sum2_q             <= sum2;
      s2_k1_q               <= k1;
      s2_k2_q               <= k2;
      s2_flags_q.two        <= s1_op_i.pixel & s1_op_i.emit2;
      s2_flags_q.frame_done <= ~s1_op_i.pixel & s1_op_i.last;
    end
  end

  assign s2_busy_o    = s2_valid_q;
  assign res_valid_o  = s2_valid_q;
  assign res_first_o  = div_mean(s2_sum1_q, s2_k1_q);
  assign res_second_o = div_mean(s2_sum2_q, s2_k2_q);
  assign res_flags_o  = s2_flags_q;

  // A row-end pair never carries the end-of-frame mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_flags_q.two) |-> !s2_flags_q.frame_done)
    else $error("two-result transaction marked as frame end");

endmodule

### design/nms_back.sv
// Back end: result queue and output serializer.
module nms_back import nms_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  input  logic [PIXEL_BITS-1:0] res_first_i,
  input  logic [PIXEL_BITS-1:0] res_second_i,
  input  res_flags_t            res_flags_i,
  output logic [FIFO_CNT_W-1:0] fifo_count_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] smoothed_o,
  output logic                  frame_done_o,
  output logic                  run_end_o
);

  logic [PIXEL_BITS-1:0] first_q  [FIFO_DEPTH];
  logic [PIXEL_BITS-1:0] second_q [FIFO_DEPTH];
  res_flags_t            flags_q  [FIFO_DEPTH];

  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  half_q;
  res_flags_t            head_flags;
  logic                  push, pop, out_acc;

  assign head_flags   = flags_q[rd_ptr_q];
  assign out_valid_o  = (count_q != '0);
  assign smoothed_o   = half_q ? second_q[rd_ptr_q] : first_q[rd_ptr_q];
  assign run_end_o    = half_q | ~head_flags.two;
  assign frame_done_o = head_flags.frame_done;
  assign out_acc      = out_valid_o & out_ready_i;
  assign pop          = out_acc & run_end_o;
  assign push         = res_valid_i;
  assign fifo_count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      half_q   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      if (out_acc) begin
        half_q <= ~run_end_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      first_q[wr_ptr_q]  <= res_first_i;
      second_q[wr_ptr_q] <= res_second_i;
      flags_q[wr_ptr_q]  <= res_flags_i;
    end
  end

  // The front end only accepts work that is sure to find room here.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (count_q < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // The second half of an entry is only reached for row-end pairs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> (out_valid_o && head_flags.two))
    else $error("second result selected on a single-result entry");

endmodule
